[rtl/drt_pkg.sv]
// Shared types and constants of the dirty rectangle tracker.
`timescale 1ns / 1ps
package drt_pkg;

  // Request codes on func
  localparam logic [1:0] FUNC_MARK    = 2'd0;
  localparam logic [1:0] FUNC_CONSUME = 2'd1;
  localparam logic [1:0] FUNC_DISCARD = 2'd2;

  // Register indexes (word address)
  localparam logic REG_SCREEN_W = 1'b0;
  localparam logic REG_SCREEN_H = 1'b1;

  localparam logic [9:0] SCREEN_W_RST = 10'd135;
  localparam logic [9:0] SCREEN_H_RST = 10'd240;

  // Most results a single consume returns
  localparam int unsigned RESULT_LIMIT = 8;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [9:0] w;
    logic [9:0] h;
  } rect_t;

  // Commands from the sequencer to every cell
  typedef struct packed {
    logic shift;  // take the neighbor's entry (consume drain)
    logic load;   // head cell only: store the rectangle bus as is
  } cell_ctl_t;

  // Per-cell search outcome in the current cycle
  typedef struct packed {
    logic done;   // token stopped here (merged or appended)
    logic app;    // token stopped here by appending
  } cell_sts_t;

endpackage

[rtl/drt_cell.sv]
// One list slot: holds an entry, tests the passing search token against it.
`timescale 1ns / 1ps
module drt_cell #(
  parameter int CNT_W = 4,
  parameter int IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drt_pkg::cell_ctl_t ctl_i,
  input  drt_pkg::rect_t     rect_i,
  input  logic [9:0]         scr_w_i,
  input  logic [9:0]         scr_h_i,
  input  logic [CNT_W-1:0]   cnt_i,
  input  drt_pkg::rect_t     nxt_i,
  input  logic               tok_i,
  output logic               tok_o,
  output drt_pkg::rect_t     ent_o,
  output drt_pkg::cell_sts_t sts_o
);
  import drt_pkg::*;

  rect_t ent_q, ent_d;
  logic  tok_q, tok_d;
  logic  below, at, ovl;
  rect_t merged;

  // Touching counts as overlap.
  function automatic logic axis_ovl(logic [9:0] p, logic [9:0] l,
                                    logic [9:0] dp, logic [9:0] dl);
    logic [10:0] e, de;
    e  = {1'b0, p} + {1'b0, l};
    de = {1'b0, dp} + {1'b0, dl};
    return !((e < {1'b0, dp}) || (de < {1'b0, p}));
  endfunction

  // Bounding span, clipped to the screen edge, floored at zero length.
  function automatic logic [19:0] axis_merge(logic [9:0] p, logic [9:0] l,
                                             logic [9:0] dp, logic [9:0] dl,
                                             logic [9:0] lim);
    logic [10:0] e, de, far;
    logic [9:0]  near, len;
    e    = {1'b0, p} + {1'b0, l};
    de   = {1'b0, dp} + {1'b0, dl};
    near = (p < dp) ? p : dp;
    far  = (e > de) ? e : de;
    if (far > {1'b0, lim}) begin
      len = (near >= lim) ? 10'd0 : lim - near;
    end else begin
      len = 10'(far - {1'b0, near});
    end
    return {near, len};
  endfunction

  assign below = cnt_i > CNT_W'(IDX);
  assign at    = cnt_i == CNT_W'(IDX);
  assign ovl   = axis_ovl(rect_i.x, rect_i.w, ent_q.x, ent_q.w) &&
                 axis_ovl(rect_i.y, rect_i.h, ent_q.y, ent_q.h);

  always_comb begin
    {merged.x, merged.w} = axis_merge(rect_i.x, rect_i.w, ent_q.x, ent_q.w, scr_w_i);
    {merged.y, merged.h} = axis_merge(rect_i.y, rect_i.h, ent_q.y, ent_q.h, scr_h_i);
  end

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.shift) begin
      ent_d = nxt_i;
    end else if (ctl_i.load && (IDX == 0)) begin
      ent_d = rect_i;
    end else if (tok_i && below && ovl) begin
      ent_d = merged;
    end else if (tok_i && at) begin
      ent_d = rect_i;
    end
  end

  assign tok_d      = tok_i && below && !ovl;
  assign sts_o.done = tok_i && ((below && ovl) || at);
  assign sts_o.app  = tok_i && at;

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign ent_o = ent_q;

endmodule

[rtl/dirty_rect_tracker.sv]
// Top level of the dirty rectangle tracker: sequencer, clip, cell row, output register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per transfer:
//   mark (func 0) a rectangle dirty, consume (func 1) the list, discard (func 2).
//   Output channel (out_valid_o / out_stall_i) carries the consume results.
//   APB port: screen_width at 0x0, screen_height at 0x4, 10 bits, no wait states.
// Timing:
//   A mark is clipped on transfer; a search token then walks the cell row one
//   cell per cycle while the input is held, stopping at the first overlapping
//   entry or the first free slot; a full list collapses to one full-screen entry.
//   Discard, unknown codes and marks that clip to nothing do not hold the input.
//   A consume drains the row toward the head cell, one result per output
//   transfer: n results (at most 8), the first loaded into the output register
//   once the request has put the sequencer into its emit state.
//   A stalled output holds its result; the drain waits for it.
// Reset: list empty, screen 135 x 240. Stored entries need no clearing.
`timescale 1ns / 1ps
module dirty_rect_tracker #(
  parameter int DIRTY_CAPACITY = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] rect_x_i,
  input  logic signed [15:0] rect_y_i,
  input  logic signed [15:0] rect_w_i,
  input  logic signed [15:0] rect_h_i,
  input  logic [7:0]         max_items_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         out_x_o,
  output logic [9:0]         out_y_o,
  output logic [9:0]         out_w_o,
  output logic [9:0]         out_h_o,
  output logic [2:0]         entry_index_o,
  output logic               none_returned_o,
  output logic               last_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import drt_pkg::*;

  localparam int CNT_W = $clog2(DIRTY_CAPACITY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [9:0] pos;
    logic [9:0] len;
  } axis_t;

  // Clip one axis of the incoming rectangle, wide enough for any 16-bit input.
  function automatic axis_t clip_axis(logic signed [15:0] p, logic signed [15:0] l,
                                      logic [9:0] lim);
    logic signed [17:0] pe, le, p1, l1, s, l2, lim18;
    axis_t r;
    pe    = $signed({{2{p[15]}}, p});
    le    = $signed({{2{l[15]}}, l});
    lim18 = $signed({8'd0, lim});
    p1    = p[15] ? 18'sd0 : pe;
    l1    = p[15] ? pe + le : le;
    s     = p1 + l1;
    l2    = (s > lim18) ? lim18 - p1 : l1;
    r.ok  = l2 > 18'sd0;
    r.pos = p1[9:0];
    r.len = l2[9:0];
    return r;
  endfunction

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [9:0]       scr_w_q, scr_h_q;
  rect_t            rect_q;
  logic             start_q, start_d;
  logic [3:0]       n_q, k_q;
  logic             none_q;

  logic             acc, out_free, load_out, collapse, done_any, app_any;
  logic             cfg_wr;
  axis_t            ax_x, ax_y;
  logic [7:0]       cnt8, m1, m2;
  rect_t            rect_bus, full_rect;
  cell_ctl_t        ctl;

  logic             out_valid_q;
  rect_t            out_q;
  logic [2:0]       out_idx_q;
  logic             out_none_q, out_last_q;

  logic  [DIRTY_CAPACITY:0]   tok;
  rect_t [DIRTY_CAPACITY-1:0] ent;
  cell_sts_t [DIRTY_CAPACITY-1:0] sts;
  logic  [DIRTY_CAPACITY-1:0] done_v, app_v;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= SCREEN_W_RST;
      scr_h_q <= SCREEN_H_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SCREEN_W) begin
        scr_w_q <= pwdata[9:0];
      end else begin
        scr_h_q <= pwdata[9:0];
      end
    end
  end

  assign prdata = {22'd0, (paddr[2] == REG_SCREEN_H) ? scr_h_q : scr_w_q};

  // ---------------- request decode ----------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign acc        = in_valid_i && !in_stall_o;

  assign ax_x = clip_axis(rect_x_i, rect_w_i, scr_w_q);
  assign ax_y = clip_axis(rect_y_i, rect_h_i, scr_h_q);

  // Consume run length: min(count, max_items, result limit)
  assign cnt8 = 8'(cnt_q);
  assign m1   = (cnt8 < max_items_i) ? cnt8 : max_items_i;
  assign m2   = (m1 > 8'(RESULT_LIMIT)) ? 8'(RESULT_LIMIT) : m1;

  // ---------------- cell row ----------------
  // The token enters the head cell in the cycle after the mark transfer and moves
  // one cell per cycle. A token leaving the tail means the list was full.
  assign tok[0]   = start_q;
  assign collapse = (state_q == ST_SEARCH) && tok[DIRTY_CAPACITY];

  assign full_rect = '{x: 10'd0, y: 10'd0, w: scr_w_q, h: scr_h_q};
  assign rect_bus  = collapse ? full_rect : rect_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_EMIT) && out_free;

  assign ctl.shift = load_out && !none_q;
  assign ctl.load  = collapse;

  for (genvar i = 0; i < DIRTY_CAPACITY; i++) begin : g_cell
    drt_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .rect_i  (rect_bus),
      .scr_w_i (scr_w_q),
      .scr_h_i (scr_h_q),
      .cnt_i   (cnt_q),
      .nxt_i   ((i == DIRTY_CAPACITY - 1) ? ent[i] : ent[(i + 1) % DIRTY_CAPACITY]),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1]),
      .ent_o   (ent[i]),
      .sts_o   (sts[i])
    );
    assign done_v[i] = sts[i].done;
    assign app_v[i]  = sts[i].app;
  end

  assign done_any = |done_v;
  assign app_any  = |app_v;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    start_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (func_i)
            FUNC_MARK: begin
              if (ax_x.ok && ax_y.ok) begin
                start_d = 1'b1;
                state_d = ST_SEARCH;
              end
            end
            FUNC_CONSUME: state_d = ST_EMIT;
            FUNC_DISCARD: cnt_d = '0;
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (done_any) begin
          if (app_any) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end else if (collapse) begin
          cnt_d   = CNT_W'(1);
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          if (none_q) begin
            state_d = ST_IDLE;
          end else if (4'(k_q + 4'd1) == n_q) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      start_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      if (acc) begin
        k_q <= '0;
      end else if (load_out) begin
        k_q <= k_q + 4'd1;
      end
    end
  end

  // Request payload, held for the search or the drain
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rect_q <= '{x: ax_x.pos, y: ax_y.pos, w: ax_x.len, h: ax_y.len};
      n_q    <= m2[3:0];
      none_q <= (cnt_q == '0) || (max_items_i == 8'd0);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q      <= none_q ? '0 : ent[0];
      out_idx_q  <= none_q ? 3'd0 : k_q[2:0];
      out_none_q <= none_q;
      out_last_q <= none_q || (4'(k_q + 4'd1) == n_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = out_q.x;
  assign out_y_o         = out_q.y;
  assign out_w_o         = out_q.w;
  assign out_h_o         = out_q.h;
  assign entry_index_o   = out_idx_q;
  assign none_returned_o = out_none_q;
  assign last_o          = out_last_q;

endmodule

[rtl/drt_checker.sv]
// Port-level assertions for the dirty rectangle tracker, bound to the top level.
`timescale 1ns / 1ps
module drt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [9:0] out_x_o,
  input logic [9:0] out_w_o,
  input logic [2:0] entry_index_o,
  input logic       none_returned_o,
  input logic       last_o
);

  // Empty consume result is a single, zeroed, final transfer
  a_none_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_returned_o |->
      last_o && (entry_index_o == 3'd0) && (out_x_o == 10'd0) && (out_w_o == 10'd0))
    else $error("empty consume result malformed");

  // Within a run, the next result follows the transfer at once, index up by one
  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && (entry_index_o == 3'($past(entry_index_o) + 3'd1)))
    else $error("consume run broken or index skipped");

  // No new request is taken while a consume run is unfinished
  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("request taken during a consume run");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(entry_index_o) && $stable(last_o) && $stable(out_x_o))
    else $error("stalled result changed");

endmodule

bind dirty_rect_tracker drt_checker u_drt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_x_o         (out_x_o),
  .out_w_o         (out_w_o),
  .entry_index_o   (entry_index_o),
  .none_returned_o (none_returned_o),
  .last_o          (last_o)
);
